// ===== sv/rsal_pkg.sv =====
// rsal_pkg: shared constants and types for the record slot avail list
`timescale 1ns / 1ps
package rsal_pkg;

	localparam int RECORD_SLOTS = 32;
	localparam int RECORD_CHARS = 8;

	localparam int REC_W       = 8 * RECORD_CHARS;
	localparam int SLOT_W      = $clog2(RECORD_SLOTS);
	localparam int CNT_W       = $clog2(RECORD_SLOTS + 1);
	localparam int VALUE_W     = 64;
	localparam int SLOT_OUT_W  = 5;
	localparam int COUNT_OUT_W = 6;

	// commands
	localparam logic [1:0] CMD_ADD  = 2'd0;
	localparam logic [1:0] CMD_DEL  = 2'd1;
	localparam logic [1:0] CMD_CMP  = 2'd2;
	localparam logic [1:0] CMD_DUMP = 2'd3;

	// result status codes
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_FULL      = 2'd1;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
	localparam logic [1:0] STAT_EMPTY     = 2'd3;

	// broadcast operations for the cell row
	localparam logic [2:0] CELL_HOLD   = 3'd0;
	localparam logic [2:0] CELL_WRITE  = 3'd1;
	localparam logic [2:0] CELL_MARK   = 3'd2;
	localparam logic [2:0] CELL_SHIFT  = 3'd3;
	localparam logic [2:0] CELL_ROTATE = 3'd4;
	localparam logic [2:0] CELL_CLEAR  = 3'd5;

	typedef struct packed {
		logic [2:0]        op;
		logic [SLOT_W-1:0] sel;     // target slot, or first slot of a shift
		logic [SLOT_W-1:0] close;   // slot that closes the rotate ring
		logic [REC_W-1:0]  data;    // write data and compare key
		logic [SLOT_W-1:0] link;    // next index pushed on delete
		logic              link_v;
	} cell_ctl_t;

	typedef struct packed {
		logic [REC_W-1:0] rec;
		logic             del;
	} cell_data_t;

endpackage

// ===== sv/record_slot_avail_list.sv =====
// record_slot_avail_list: top level, cell row plus command sequencer
`timescale 1ns / 1ps
// Fixed-length record table of RECORD_SLOTS slots, each slot a cell in a row.
// One command is taken at a time; in_stall stays high until the command's last
// result word has been loaded into the output register, which then waits on
// out_stall independently. Delete walks the cells one per cycle up to the first
// live match or to the used count; compact walks the used slots one per cycle,
// moving the tail of the row left past each deleted slot; dump is a compact
// followed by one result word per record, produced by rotating the row one cell
// per cycle while the output is not stalled, with slot 0 as the output tap, or
// by a single result word when no record is left. No clearing pass follows
// reset.
module record_slot_avail_list import rsal_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             cmd,
	input  logic [VALUE_W-1:0]     record_value,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             status,
	output logic [SLOT_OUT_W-1:0]  slot,
	output logic [COUNT_OUT_W-1:0] record_count,
	output logic [VALUE_W-1:0]     record_out,
	output logic                   last
);

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ADD  = 3'd1;
	localparam logic [2:0] ST_DEL  = 3'd2;
	localparam logic [2:0] ST_CMP  = 3'd3;
	localparam logic [2:0] ST_DUMP = 3'd4;
	localparam logic [2:0] ST_RESP = 3'd5;

	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(RECORD_SLOTS);

	logic [2:0]        state_q;
	logic [1:0]        cmd_q;
	logic [REC_W-1:0]  key_q;
	logic [CNT_W-1:0]  used_q;
	logic [SLOT_W-1:0] head_q;
	logic              head_v_q;
	logic [CNT_W-1:0]  ptr_q;      // scan index, compaction read count, dump index
	logic [CNT_W-1:0]  wr_q;       // compaction write index
	logic [1:0]        res_status_q;
	logic [SLOT_W-1:0] res_slot_q;

	logic                   out_valid_q;
	logic [1:0]             status_q;
	logic [SLOT_OUT_W-1:0]  slot_q;
	logic [COUNT_OUT_W-1:0] count_q;
	logic [VALUE_W-1:0]     record_out_q;
	logic                   last_q;

	// cell row
	cell_ctl_t         ctl;
	cell_data_t        cur   [RECORD_SLOTS];
	cell_data_t        right [RECORD_SLOTS];
	logic [SLOT_W-1:0] nxt_a [RECORD_SLOTS];
	logic              nxtv_a [RECORD_SLOTS];
	logic              hit_a [RECORD_SLOTS];

	genvar gi;
	generate
		for (gi = 0; gi < RECORD_SLOTS; gi++) begin : g_cell
			// the last cell feeds itself; anything past the table end is don't care
			if (gi == RECORD_SLOTS - 1) begin : g_end
				assign right[gi] = cur[gi];
			end else begin : g_mid
				assign right[gi] = cur[gi + 1];
			end
			rsal_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.idx      (SLOT_W'(gi)),
				.ctl      (ctl),
				.right    (right[gi]),
				.head_rec (cur[0].rec),
				.cur      (cur[gi]),
				.nxt      (nxt_a[gi]),
				.nxt_v    (nxtv_a[gi]),
				.hit      (hit_a[gi])
			);
		end
	endgenerate

	// handshake helpers
	logic in_take;
	logic out_free;
	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// taps into the row
	logic [SLOT_W-1:0] scan_idx;
	logic [SLOT_W-1:0] wr_idx;
	logic [SLOT_W-1:0] used_idx;
	logic [CNT_W-1:0]  used_m1;
	logic [CNT_W-1:0]  ptr_p1;
	logic              scan_end;
	logic              hit_sel;
	logic              del_w;
	logic              dump_last;

	assign scan_idx  = ptr_q[SLOT_W-1:0];
	assign wr_idx    = wr_q[SLOT_W-1:0];
	assign used_idx  = used_q[SLOT_W-1:0];
	assign used_m1   = used_q - CNT_W'(1);
	assign ptr_p1    = ptr_q + CNT_W'(1);
	assign scan_end  = (ptr_q == used_q);
	assign hit_sel   = hit_a[scan_idx];
	assign del_w     = cur[wr_idx].del;
	assign dump_last = (ptr_p1 == used_q);

	// broadcast to the cells
	always_comb begin
		ctl.op     = CELL_HOLD;
		ctl.sel    = head_q;
		ctl.close  = used_m1[SLOT_W-1:0];
		ctl.data   = key_q;
		ctl.link   = head_q;
		ctl.link_v = head_v_q;
		unique case (state_q)
			ST_ADD: begin
				if (head_v_q) begin
					ctl.op = CELL_WRITE;
				end else if (used_q != FULL_COUNT) begin
					ctl.op  = CELL_WRITE;
					ctl.sel = used_idx;
				end
			end
			ST_DEL: begin
				if (!scan_end && hit_sel) begin
					ctl.op  = CELL_MARK;
					ctl.sel = scan_idx;
				end
			end
			ST_CMP: begin
				if (scan_end) begin
					ctl.op = CELL_CLEAR;
				end else if (del_w) begin
					// drop the deleted slot by moving the rest of the row left
					ctl.op  = CELL_SHIFT;
					ctl.sel = wr_idx;
				end
			end
			ST_DUMP: begin
				if (out_free) ctl.op = CELL_ROTATE;
			end
			default: begin
			end
		endcase
	end

	// sequencer and table bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			used_q   <= '0;
			head_q   <= '0;
			head_v_q <= 1'b0;
			ptr_q    <= '0;
			wr_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						ptr_q <= '0;
						wr_q  <= '0;
						unique case (cmd)
							CMD_ADD:  state_q <= ST_ADD;
							CMD_DEL:  state_q <= ST_DEL;
							CMD_CMP:  state_q <= ST_CMP;
							CMD_DUMP: state_q <= ST_CMP;
							default:  state_q <= ST_IDLE;
						endcase
					end
				end
				ST_ADD: begin
					// reuse the most recently freed slot, else append
					if (head_v_q) begin
						head_q   <= nxt_a[head_q];
						head_v_q <= nxtv_a[head_q];
					end else if (used_q != FULL_COUNT) begin
						used_q <= used_q + CNT_W'(1);
					end
					state_q <= ST_RESP;
				end
				ST_DEL: begin
					if (scan_end) begin
						state_q <= ST_RESP;
					end else if (hit_sel) begin
						head_q   <= scan_idx;
						head_v_q <= 1'b1;
						state_q  <= ST_RESP;
					end else begin
						ptr_q <= ptr_p1;
					end
				end
				ST_CMP: begin
					if (scan_end) begin
						used_q   <= wr_q;
						head_q   <= '0;
						head_v_q <= 1'b0;
						ptr_q    <= '0;
						if (cmd_q == CMD_DUMP && wr_q != '0) begin
							state_q <= ST_DUMP;
						end else begin
							state_q <= ST_RESP;
						end
					end else begin
						ptr_q <= ptr_p1;
						if (!del_w) wr_q <= wr_q + CNT_W'(1);
					end
				end
				ST_DUMP: begin
					if (out_free) begin
						ptr_q <= ptr_p1;
						if (dump_last) state_q <= ST_IDLE;
					end
				end
				ST_RESP: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// command word and pending single result
	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_q <= cmd;
			key_q <= record_value[REC_W-1:0];
		end
		unique case (state_q)
			ST_ADD: begin
				if (head_v_q) begin
					res_status_q <= STAT_OK;
					res_slot_q   <= head_q;
				end else if (used_q != FULL_COUNT) begin
					res_status_q <= STAT_OK;
					res_slot_q   <= used_idx;
				end else begin
					res_status_q <= STAT_FULL;
					res_slot_q   <= '0;
				end
			end
			ST_DEL: begin
				if (scan_end) begin
					res_status_q <= STAT_NOT_FOUND;
					res_slot_q   <= '0;
				end else if (hit_sel) begin
					res_status_q <= STAT_OK;
					res_slot_q   <= scan_idx;
				end
			end
			ST_CMP: begin
				// compaction done: ok for compact, empty for a dump of nothing
				if (scan_end) begin
					res_status_q <= (cmd_q == CMD_DUMP) ? STAT_EMPTY : STAT_OK;
					res_slot_q   <= '0;
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	logic load_resp;
	logic load_dump;
	assign load_resp = (state_q == ST_RESP) && out_free;
	assign load_dump = (state_q == ST_DUMP) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_resp || load_dump) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_resp) begin
			status_q     <= res_status_q;
			slot_q       <= SLOT_OUT_W'(res_slot_q);
			count_q      <= COUNT_OUT_W'(used_q);
			record_out_q <= '0;
			last_q       <= 1'b1;
		end else if (load_dump) begin
			// slot 0 of the rotating row is the output tap
			status_q     <= STAT_OK;
			slot_q       <= SLOT_OUT_W'(scan_idx);
			count_q      <= COUNT_OUT_W'(used_q);
			record_out_q <= VALUE_W'(cur[0].rec);
			last_q       <= dump_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign slot         = slot_q;
	assign record_count = count_q;
	assign record_out   = record_out_q;
	assign last         = last_q;

endmodule

// ===== sv/rsal_cell.sv =====
// rsal_cell: one slot of the record table with its deleted flag and free link
`timescale 1ns / 1ps
module rsal_cell import rsal_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [SLOT_W-1:0] idx,
	input  cell_ctl_t         ctl,
	input  cell_data_t        right,
	input  logic [REC_W-1:0]  head_rec,
	output cell_data_t        cur,
	output logic [SLOT_W-1:0] nxt,
	output logic              nxt_v,
	output logic              hit
);

	logic [REC_W-1:0]  rec_q;
	logic [SLOT_W-1:0] nxt_q;
	logic              del_q;
	logic              nxt_v_q;
	logic              is_sel;
	logic              at_or_after;
	logic              is_close;

	assign is_sel      = (idx == ctl.sel);
	assign at_or_after = (idx >= ctl.sel);
	assign is_close    = (idx == ctl.close);

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			CELL_WRITE: begin
				if (is_sel) rec_q <= ctl.data;
			end
			CELL_MARK: begin
				if (is_sel) nxt_q <= ctl.link;
			end
			CELL_SHIFT: begin
				if (at_or_after) rec_q <= right.rec;
			end
			CELL_ROTATE: begin
				rec_q <= is_close ? head_rec : right.rec;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			del_q   <= 1'b0;
			nxt_v_q <= 1'b0;
		end else begin
			unique case (ctl.op)
				CELL_WRITE: begin
					if (is_sel) begin
						del_q   <= 1'b0;
						nxt_v_q <= 1'b0;
					end
				end
				CELL_MARK: begin
					if (is_sel) begin
						del_q   <= 1'b1;
						nxt_v_q <= ctl.link_v;
					end
				end
				CELL_SHIFT: begin
					if (at_or_after) del_q <= right.del;
				end
				CELL_CLEAR: begin
					del_q   <= 1'b0;
					nxt_v_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// live record equal to the key
	assign hit   = !del_q && (rec_q == ctl.data);
	assign cur   = '{rec: rec_q, del: del_q};
	assign nxt   = nxt_q;
	assign nxt_v = nxt_v_q;

endmodule
